[src/psd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and width helpers for the point-to-segment
// squared distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int AXES           = 3;
   localparam int DIR_BITS       = 16;
   localparam int OUT_BITS       = 50;
   localparam int MAG_BITS       = OUT_BITS / 2;
   localparam int RSP_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_BITS = 3;

   // pipeline stage positions
   localparam int NUM_STAGES   = 8;
   localparam int ST_DOT_MUL   = 0;
   localparam int ST_DOT_SUM   = 1;
   localparam int ST_SCALE_MUL = 2;
   localparam int ST_PROJ      = 3;
   localparam int ST_TEST      = 4;
   localparam int ST_PICK      = 5;
   localparam int ST_SQUARE    = 6;
   localparam int ST_SUM       = 7;

   typedef logic [NUM_STAGES-1:0] stage_en_type;

   typedef enum logic [1:0] {
      KIND_PROJ  = 2'd0,
      KIND_START = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // rounded projection parameter t
   function automatic int t_bits(int cb, int dfb);
      return cb + 20 - dfb;
   endfunction

   // rounded offset t * dir along one axis
   function automatic int off_bits(int cb, int dfb);
      int w;
      w = t_bits(cb, dfb) + DIR_BITS - dfb + 1;
      return (w > 2) ? w : 2;
   endfunction

   // projected point coordinate
   function automatic int q_bits(int cb, int dfb);
      int ob;
      ob = off_bits(cb, dfb);
      return ((cb > ob) ? cb : ob) + 1;
   endfunction

endpackage

[src/psd_proj.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_proj
// Four-stage projection of P onto the line S + t * D: dot product products,
// rounded sum t, scaled direction products, rounded offset added to S.
// ----------------------------------------------------------------------------
module psd_proj #(
   parameter int  COORD_BITS    = 24,
   parameter int  DIR_FRAC_BITS = 14,
   localparam int Q_BITS        = psd_pkg::q_bits(COORD_BITS, DIR_FRAC_BITS)
) (
   input  logic                         clock,
   input  psd_pkg::stage_en_type        stage_en,
   input  logic signed [COORD_BITS-1:0] p_in   [psd_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] s_in   [psd_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] e_in   [psd_pkg::AXES],
   input  logic signed [psd_pkg::DIR_BITS-1:0] dir_in [psd_pkg::AXES],
   output logic signed [Q_BITS-1:0]     q_out  [psd_pkg::AXES],
   output logic signed [COORD_BITS-1:0] p_out  [psd_pkg::AXES],
   output logic signed [COORD_BITS-1:0] s_out  [psd_pkg::AXES],
   output logic signed [COORD_BITS-1:0] e_out  [psd_pkg::AXES]
);
   import psd_pkg::*;

   localparam int D_BITS     = COORD_BITS + 1;
   localparam int PROD1_BITS = D_BITS + DIR_BITS;
   localparam int DOT_BITS   = COORD_BITS + 19;
   localparam int R1_BITS    = DOT_BITS + 1;
   localparam int T_BITS     = t_bits(COORD_BITS, DIR_FRAC_BITS);
   localparam int PROD2_BITS = T_BITS + DIR_BITS;
   localparam int R2_BITS    = ((PROD2_BITS > DIR_FRAC_BITS) ? PROD2_BITS : DIR_FRAC_BITS) + 2;
   localparam int OFF_BITS   = off_bits(COORD_BITS, DIR_FRAC_BITS);

   localparam logic signed [R1_BITS-1:0] R1_HALF =
      {{(R1_BITS - DIR_FRAC_BITS){1'b0}}, 1'b1, {(DIR_FRAC_BITS - 1){1'b0}}};
   localparam logic signed [R2_BITS-1:0] R2_HALF =
      {{(R2_BITS - DIR_FRAC_BITS){1'b0}}, 1'b1, {(DIR_FRAC_BITS - 1){1'b0}}};

   // stage 1: (P - S) * D per axis
   logic signed [PROD1_BITS-1:0] prod1_in  [AXES];
   logic signed [PROD1_BITS-1:0] prod1_ff  [AXES];
   logic signed [COORD_BITS-1:0] p1_ff     [AXES];
   logic signed [COORD_BITS-1:0] s1_ff     [AXES];
   logic signed [COORD_BITS-1:0] e1_ff     [AXES];
   logic signed [DIR_BITS-1:0]   dir1_ff   [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         prod1_in[i] = PROD1_BITS'(D_BITS'(p_in[i]) - D_BITS'(s_in[i]))
                       * PROD1_BITS'(dir_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_DOT_MUL]) begin
         prod1_ff <= prod1_in;
         p1_ff    <= p_in;
         s1_ff    <= s_in;
         e1_ff    <= e_in;
         dir1_ff  <= dir_in;
      end
   end

   // stage 2: dot sum, rounded half away from zero to t
   logic signed [DOT_BITS-1:0] dot;
   logic signed [R1_BITS-1:0]  dot_rnd;
   logic signed [R1_BITS-1:0]  dot_sh;
   logic signed [T_BITS-1:0]   t_in;
   logic signed [T_BITS-1:0]   t_ff;
   logic signed [COORD_BITS-1:0] p2_ff   [AXES];
   logic signed [COORD_BITS-1:0] s2_ff   [AXES];
   logic signed [COORD_BITS-1:0] e2_ff   [AXES];
   logic signed [DIR_BITS-1:0]   dir2_ff [AXES];

   always_comb begin
      dot     = DOT_BITS'(prod1_ff[0]) + DOT_BITS'(prod1_ff[1]) + DOT_BITS'(prod1_ff[2]);
      dot_rnd = R1_BITS'(dot) + R1_HALF
                - R1_BITS'($signed({1'b0, dot[DOT_BITS-1]}));
      dot_sh  = dot_rnd >>> DIR_FRAC_BITS;
      t_in    = dot_sh[T_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_DOT_SUM]) begin
         t_ff    <= t_in;
         p2_ff   <= p1_ff;
         s2_ff   <= s1_ff;
         e2_ff   <= e1_ff;
         dir2_ff <= dir1_ff;
      end
   end

   // stage 3: t * D per axis
   logic signed [PROD2_BITS-1:0] prod2_in [AXES];
   logic signed [PROD2_BITS-1:0] prod2_ff [AXES];
   logic signed [COORD_BITS-1:0] p3_ff    [AXES];
   logic signed [COORD_BITS-1:0] s3_ff    [AXES];
   logic signed [COORD_BITS-1:0] e3_ff    [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         prod2_in[i] = PROD2_BITS'(t_ff) * PROD2_BITS'(dir2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SCALE_MUL]) begin
         prod2_ff <= prod2_in;
         p3_ff    <= p2_ff;
         s3_ff    <= s2_ff;
         e3_ff    <= e2_ff;
      end
   end

   // stage 4: round the offset and add it to S
   logic signed [R2_BITS-1:0]    off_rnd [AXES];
   logic signed [R2_BITS-1:0]    off_sh  [AXES];
   logic signed [OFF_BITS-1:0]   off     [AXES];
   logic signed [Q_BITS-1:0]     q_in    [AXES];
   logic signed [Q_BITS-1:0]     q_ff    [AXES];
   logic signed [COORD_BITS-1:0] p4_ff   [AXES];
   logic signed [COORD_BITS-1:0] s4_ff   [AXES];
   logic signed [COORD_BITS-1:0] e4_ff   [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         off_rnd[i] = R2_BITS'(prod2_ff[i]) + R2_HALF
                      - R2_BITS'($signed({1'b0, prod2_ff[i][PROD2_BITS-1]}));
         off_sh[i]  = off_rnd[i] >>> DIR_FRAC_BITS;
         off[i]     = off_sh[i][OFF_BITS-1:0];
         q_in[i]    = Q_BITS'(s3_ff[i]) + Q_BITS'(off[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_PROJ]) begin
         q_ff  <= q_in;
         p4_ff <= p3_ff;
         s4_ff <= s3_ff;
         e4_ff <= e3_ff;
      end
   end

   assign q_out = q_ff;
   assign p_out = p4_ff;
   assign s_out = s4_ff;
   assign e_out = e4_ff;

endmodule

[src/psd_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_select
// Two stages: per-axis outside and nearer-endpoint tests on Q, then the
// first-axis pick, the difference vector and its per-axis magnitude.
// ----------------------------------------------------------------------------
module psd_select #(
   parameter int  COORD_BITS    = 24,
   parameter int  DIR_FRAC_BITS = 14,
   localparam int Q_BITS        = psd_pkg::q_bits(COORD_BITS, DIR_FRAC_BITS)
) (
   input  logic                         clock,
   input  psd_pkg::stage_en_type        stage_en,
   input  logic signed [Q_BITS-1:0]     q_in  [psd_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] p_in  [psd_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] s_in  [psd_pkg::AXES],
   input  logic signed [COORD_BITS-1:0] e_in  [psd_pkg::AXES],
   output logic [psd_pkg::MAG_BITS-1:0] mag_out [psd_pkg::AXES],
   output logic                         big_out,
   output psd_pkg::kind_type            kind_out
);
   import psd_pkg::*;

   localparam int QD_BITS   = Q_BITS + 1;
   localparam int DIFF_BITS = (Q_BITS + 1 > MAG_BITS + 1) ? Q_BITS + 1 : MAG_BITS + 1;

   // stage 5: axis tests
   logic signed [Q_BITS-1:0]     qs [AXES];
   logic signed [Q_BITS-1:0]     qe [AXES];
   logic signed [QD_BITS-1:0]    dqs [AXES];
   logic signed [QD_BITS-1:0]    dqe [AXES];
   logic [QD_BITS-1:0]           adqs [AXES];
   logic [QD_BITS-1:0]           adqe [AXES];
   logic [AXES-1:0]              outside_in;
   logic [AXES-1:0]              outside_ff;
   logic [AXES-1:0]              near_start_in;
   logic [AXES-1:0]              near_start_ff;
   logic signed [Q_BITS-1:0]     q5_ff [AXES];
   logic signed [COORD_BITS-1:0] p5_ff [AXES];
   logic signed [COORD_BITS-1:0] s5_ff [AXES];
   logic signed [COORD_BITS-1:0] e5_ff [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         qs[i]   = Q_BITS'(s_in[i]);
         qe[i]   = Q_BITS'(e_in[i]);
         outside_in[i] = (q_in[i] > qs[i] && q_in[i] > qe[i]) ||
                         (q_in[i] < qs[i] && q_in[i] < qe[i]);
         dqs[i]  = QD_BITS'(q_in[i]) - QD_BITS'(qs[i]);
         dqe[i]  = QD_BITS'(q_in[i]) - QD_BITS'(qe[i]);
         adqs[i] = dqs[i][QD_BITS-1] ? QD_BITS'(-dqs[i]) : QD_BITS'(dqs[i]);
         adqe[i] = dqe[i][QD_BITS-1] ? QD_BITS'(-dqe[i]) : QD_BITS'(dqe[i]);
         near_start_in[i] = adqs[i] < adqe[i];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_TEST]) begin
         outside_ff    <= outside_in;
         near_start_ff <= near_start_in;
         q5_ff         <= q_in;
         p5_ff         <= p_in;
         s5_ff         <= s_in;
         e5_ff         <= e_in;
      end
   end

   // stage 6: first qualifying axis wins; build P - X and its magnitude
   kind_type                    kind_in;
   kind_type                    kind_ff;
   logic signed [Q_BITS-1:0]    ref_pt [AXES];
   logic signed [DIFF_BITS-1:0] diff   [AXES];
   logic [DIFF_BITS-1:0]        adiff  [AXES];
   logic [MAG_BITS-1:0]         mag_in [AXES];
   logic [MAG_BITS-1:0]         mag_ff [AXES];
   logic                        big_in;
   logic                        big_ff;

   always_comb begin
      kind_in = KIND_PROJ;
      for (int i = AXES - 1; i >= 0; i--) begin
         if (outside_ff[i]) begin
            if (near_start_ff[i]) begin
               kind_in = KIND_START;
            end else begin
               kind_in = KIND_END;
            end
         end
      end
      big_in = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         unique case (kind_in)
            KIND_START: ref_pt[i] = Q_BITS'(s5_ff[i]);
            KIND_END:   ref_pt[i] = Q_BITS'(e5_ff[i]);
            default:    ref_pt[i] = q5_ff[i];
         endcase
         diff[i]   = DIFF_BITS'(p5_ff[i]) - DIFF_BITS'(ref_pt[i]);
         adiff[i]  = diff[i][DIFF_BITS-1] ? DIFF_BITS'(-diff[i]) : DIFF_BITS'(diff[i]);
         mag_in[i] = adiff[i][MAG_BITS-1:0];
         big_in    = big_in | (|adiff[i][DIFF_BITS-1:MAG_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_PICK]) begin
         kind_ff <= kind_in;
         mag_ff  <= mag_in;
         big_ff  <= big_in;
      end
   end

   assign mag_out  = mag_ff;
   assign big_out  = big_ff;
   assign kind_out = kind_ff;

endmodule

[src/psd_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_norm
// Two stages: per-axis squares, then the sum with saturation. The last
// stage is the result register.
// ----------------------------------------------------------------------------
module psd_norm (
   input  logic                          clock,
   input  psd_pkg::stage_en_type         stage_en,
   input  logic [psd_pkg::MAG_BITS-1:0]  mag_in [psd_pkg::AXES],
   input  logic                          big_in,
   input  psd_pkg::kind_type             kind_in,
   output logic [psd_pkg::OUT_BITS-1:0]  distance_sq,
   output psd_pkg::kind_type             nearest_kind,
   output logic                          saturated
);
   import psd_pkg::*;

   localparam int SUM_BITS = OUT_BITS + 2;

   // stage 7: squares
   logic [OUT_BITS-1:0] sq_in [AXES];
   logic [OUT_BITS-1:0] sq_ff [AXES];
   logic                big_ff;
   kind_type            kind7_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sq_in[i] = OUT_BITS'(mag_in[i]) * OUT_BITS'(mag_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SQUARE]) begin
         sq_ff    <= sq_in;
         big_ff   <= big_in;
         kind7_ff <= kind_in;
      end
   end

   // stage 8: sum and clamp
   logic [SUM_BITS-1:0] sum;
   logic                sat_in;
   logic                sat_ff;
   logic [OUT_BITS-1:0] dist_in;
   logic [OUT_BITS-1:0] dist_ff;
   kind_type            kind8_ff;

   always_comb begin
      sum     = SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
      sat_in  = big_ff | (|sum[SUM_BITS-1:OUT_BITS]);
      dist_in = sat_in ? {OUT_BITS{1'b1}} : sum[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         dist_ff  <= dist_in;
         sat_ff   <= sat_in;
         kind8_ff <= kind7_ff;
      end
   end

   assign distance_sq  = dist_ff;
   assign nearest_kind = kind8_ff;
   assign saturated    = sat_ff;

endmodule

[src/point_segment_distance_sq_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_sq_unit
// Each stage holds one word; a req word passes through every stage to its rsp.
// Throughput: one word per cycle unless a low rsp_tready backs up the stages;
// a stalled stage only blocks while the stages behind it are full.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module point_segment_distance_sq_unit #(
   parameter int  COORD_BITS     = 24,
   parameter int  DIR_FRAC_BITS  = 14,
   localparam int REQ_TDATA_BITS = ((9 * COORD_BITS + 3 * 16 + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // point_x, point_y, point_z, start_x, start_y, start_z,
   // end_x, end_y, end_z, dir_x, dir_y, dir_z (zero pad on top)
   input  logic [REQ_TDATA_BITS-1:0]            req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // distance_sq (zero pad on top)
   output logic [psd_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // nearest_kind, saturated
   output logic [psd_pkg::RSP_TUSER_BITS-1:0]   rsp_tuser
);
   import psd_pkg::*;

   localparam int Q_BITS  = q_bits(COORD_BITS, DIR_FRAC_BITS);
   localparam int DIR_POS = 9 * COORD_BITS;

   // unpack the request word
   logic signed [COORD_BITS-1:0] p_in   [AXES];
   logic signed [COORD_BITS-1:0] s_in   [AXES];
   logic signed [COORD_BITS-1:0] e_in   [AXES];
   logic signed [DIR_BITS-1:0]   dir_in [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         p_in[i]   = req_tdata[i * COORD_BITS +: COORD_BITS];
         s_in[i]   = req_tdata[(AXES + i) * COORD_BITS +: COORD_BITS];
         e_in[i]   = req_tdata[(2 * AXES + i) * COORD_BITS +: COORD_BITS];
         dir_in[i] = req_tdata[DIR_POS + i * DIR_BITS +: DIR_BITS];
      end
   end

   // stage valid bits; a stage loads when empty or when it drains forward
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   stage_en_type          stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   // projection
   logic signed [Q_BITS-1:0]     q4   [AXES];
   logic signed [COORD_BITS-1:0] p4   [AXES];
   logic signed [COORD_BITS-1:0] s4   [AXES];
   logic signed [COORD_BITS-1:0] e4   [AXES];

   psd_proj #(
      .COORD_BITS    (COORD_BITS),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_proj (
      .clock    (clock),
      .stage_en (stage_en),
      .p_in     (p_in),
      .s_in     (s_in),
      .e_in     (e_in),
      .dir_in   (dir_in),
      .q_out    (q4),
      .p_out    (p4),
      .s_out    (s4),
      .e_out    (e4)
   );

   // endpoint test and difference vector
   logic [MAG_BITS-1:0] mag6 [AXES];
   logic                big6;
   kind_type            kind6;

   psd_select #(
      .COORD_BITS    (COORD_BITS),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_select (
      .clock    (clock),
      .stage_en (stage_en),
      .q_in     (q4),
      .p_in     (p4),
      .s_in     (s4),
      .e_in     (e4),
      .mag_out  (mag6),
      .big_out  (big6),
      .kind_out (kind6)
   );

   // squared length
   logic [OUT_BITS-1:0] distance_sq;
   kind_type            nearest_kind;
   logic                saturated;

   psd_norm u_norm (
      .clock        (clock),
      .stage_en     (stage_en),
      .mag_in       (mag6),
      .big_in       (big6),
      .kind_in      (kind6),
      .distance_sq  (distance_sq),
      .nearest_kind (nearest_kind),
      .saturated    (saturated)
   );

   assign rsp_tdata = {{(RSP_TDATA_BITS - OUT_BITS){1'b0}}, distance_sq};
   assign rsp_tuser = {saturated, nearest_kind};

endmodule
